// ----- sv/channel_blink_code_sequencer_macros.svh -----
// Assertion macros used by the sequencer core module.
// Each macro samples on clk_i and is off while rst_ni is low.
`ifndef CHANNEL_BLINK_CODE_SEQUENCER_MACROS_SVH
`define CHANNEL_BLINK_CODE_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define CBS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// Next-cycle implication.
`define CBS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

// ----- sv/cbs_pkg.sv -----
`timescale 1ns / 1ps

package cbs_pkg;

  localparam int unsigned MAX_ENTRIES = 20;

  localparam int unsigned NOW_W  = 32;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned UNIT_W = 4;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned COLOR_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [COLOR_W-1:0] COLOR_OFF   = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_GREEN = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_RED   = 2'd2;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HALF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_HALF = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_UNIT  = 2'd3;

  localparam logic [HALF_W-1:0] LONG_HALF_RST  = 16'd400;
  localparam logic [HALF_W-1:0] SHORT_HALF_RST = 16'd200;
  localparam logic [UNIT_W-1:0] LONG_UNIT_RST  = 4'd5;

  typedef struct packed {
    logic              enabled;
    logic [HALF_W-1:0] long_half;
    logic [HALF_W-1:0] short_half;
    logic [UNIT_W-1:0] long_unit;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] longs;
    logic [CNT_W-1:0] shorts;
  } split_t;

  typedef struct packed {
    logic               valid;
    logic [COLOR_W-1:0] color;
    logic               active;
  } result_t;

endpackage

// ----- sv/cbs_split.sv -----
`timescale 1ns / 1ps

module cbs_split import cbs_pkg::*; #(
  parameter int unsigned MaxEntries = MAX_ENTRIES
) (
  input  logic [CHAN_W-1:0] chan_i,
  input  logic [UNIT_W-1:0] unit_i,
  output split_t            split_o
);

  localparam int unsigned Cap   = MaxEntries / 2;
  localparam int unsigned ProdW = CNT_W + UNIT_W;

  logic [ProdW-1:0] mult [Cap+1];
  logic [Cap:0]     ge;

  always_comb begin
    logic [CNT_W-1:0] q;
    logic [ProdW-1:0] base;
    logic [ProdW-1:0] rem;
    logic [CNT_W-1:0] room;
    q    = '0;
    base = '0;
    for (int k = 0; k <= Cap; k++) begin
      mult[k] = ProdW'(k) * ProdW'(unit_i);
      ge[k]   = (mult[k] <= ProdW'(chan_i));
    end
    // locate the edge of the thermometer code
    for (int k = 0; k < Cap; k++) begin
      if (ge[k] && !ge[k+1]) begin
        q    = q | CNT_W'(k);
        base = base | mult[k];
      end
    end
    rem  = ProdW'(chan_i) - base;
    room = CNT_W'(Cap) - q;
    if (ge[Cap]) begin
      split_o.longs  = CNT_W'(Cap);
      split_o.shorts = '0;
    end else begin
      split_o.longs  = q;
      split_o.shorts = (rem < ProdW'(room)) ? CNT_W'(rem) : room;
    end
  end

endmodule

// ----- sv/cbs_core.sv -----
`timescale 1ns / 1ps
`include "channel_blink_code_sequencer_macros.svh"

module cbs_core import cbs_pkg::*; #(
  parameter int unsigned MaxEntries = MAX_ENTRIES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              kind_i,
  input  logic [NOW_W-1:0]  now_i,
  input  logic [CHAN_W-1:0] chan_i,
  input  logic              sysrun_i,
  input  cfg_t              cfg_i,
  output result_t           res_o
);

  logic              run_q, run_d;
  logic [NOW_W-1:0]  deadline_q, deadline_d;
  logic              off_q, off_d;
  logic [CNT_W-1:0]  long_q, long_d;
  logic [CNT_W-1:0]  short_q, short_d;
  logic              is_long_q, is_long_d;
  logic              endless_q, endless_d;

  logic [UNIT_W-1:0] unit_eff;
  split_t            split;
  logic              start_long;
  logic              tick_long;
  logic [HALF_W-1:0] start_half;
  logic [HALF_W-1:0] tick_take_half;
  logic [HALF_W-1:0] cur_half;
  logic              due;

  assign unit_eff = (cfg_i.long_unit == '0) ? UNIT_W'(1) : cfg_i.long_unit;

  cbs_split #(
    .MaxEntries(MaxEntries)
  ) u_split (
    .chan_i (chan_i),
    .unit_i (unit_eff),
    .split_o(split)
  );

  assign start_long     = (split.longs != '0);
  assign tick_long      = (long_q != '0);
  assign start_half     = start_long ? cfg_i.long_half : cfg_i.short_half;
  assign tick_take_half = tick_long ? cfg_i.long_half : cfg_i.short_half;
  assign cur_half       = is_long_q ? cfg_i.long_half : cfg_i.short_half;
  assign due            = run_q && !endless_q && (now_i > deadline_q);

  always_comb begin
    run_d      = run_q;
    deadline_d = deadline_q;
    off_d      = off_q;
    long_d     = long_q;
    short_d    = short_q;
    is_long_d  = is_long_q;
    endless_d  = endless_q;
    res_o      = '0;
    if (fire_i) begin
      if (kind_i == KIND_START) begin
        if (cfg_i.enabled) begin
          run_d        = 1'b1;
          res_o.valid  = 1'b1;
          res_o.color  = sysrun_i ? COLOR_GREEN : COLOR_RED;
          res_o.active = 1'b1;
          if (split.longs == '0 && split.shorts == '0) begin
            endless_d  = 1'b1;
            off_d      = 1'b0;
            is_long_d  = 1'b0;
            long_d     = '0;
            short_d    = '0;
            deadline_d = now_i;
          end else begin
            endless_d  = 1'b0;
            off_d      = 1'b1;
            is_long_d  = start_long;
            long_d     = split.longs - CNT_W'(start_long);
            short_d    = split.shorts - CNT_W'(!start_long);
            deadline_d = now_i + NOW_W'(start_half);
          end
        end
      end else if (due) begin
        res_o.valid = 1'b1;
        if (off_q) begin
          res_o.color = COLOR_OFF;
          off_d       = 1'b0;
          if (long_q == '0 && short_q == '0) begin
            run_d        = 1'b0;
            res_o.active = 1'b0;
          end else begin
            deadline_d   = deadline_q + NOW_W'(cur_half);
            res_o.active = 1'b1;
          end
        end else begin
          is_long_d    = tick_long;
          long_d       = long_q - CNT_W'(tick_long);
          short_d      = short_q - CNT_W'(!tick_long);
          deadline_d   = deadline_q + NOW_W'(tick_take_half);
          off_d        = 1'b1;
          res_o.color  = COLOR_GREEN;
          res_o.active = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      deadline_q <= '0;
      off_q      <= 1'b0;
      long_q     <= '0;
      short_q    <= '0;
      is_long_q  <= 1'b0;
      endless_q  <= 1'b0;
    end else begin
      run_q      <= run_d;
      deadline_q <= deadline_d;
      off_q      <= off_d;
      long_q     <= long_d;
      short_q    <= short_d;
      is_long_q  <= is_long_d;
      endless_q  <= endless_d;
    end
  end

  `CBS_ASSERT_IMP(a_hold_is_running, endless_q, run_q)
  `CBS_ASSERT_IMP(a_off_only_in_blink, off_q, run_q && !endless_q)
  `CBS_ASSERT_NXT(a_quiet_tick_keeps_deadline, fire_i && kind_i == KIND_TICK && !res_o.valid, $stable(deadline_q))

endmodule

// ----- sv/channel_blink_code_sequencer.sv -----
// A result reaches the output after its input beat is accepted, through the input
// register and then the result register. Throughput: one input beat per cycle unless
// the output stalls; a beat that causes no result is dropped in place.
// Reset: asynchronous, active low; clears the sequence state and loads the
// registers with enabled 0, long half 400, short half 200, long unit 5.
`timescale 1ns / 1ps

module channel_blink_code_sequencer import cbs_pkg::*; #(
  parameter int unsigned MaxEntries = MAX_ENTRIES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  in_kind_i,
  input  logic [NOW_W-1:0]      in_now_ms_i,
  input  logic [CHAN_W-1:0]     in_channel_i,
  input  logic                  in_system_running_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COLOR_W-1:0]    out_led_color_o,
  output logic                  out_blink_active_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t              cfg_q;
  logic              s1_valid_q;
  logic              s1_kind_q;
  logic [NOW_W-1:0]  s1_now_q;
  logic [CHAN_W-1:0] s1_chan_q;
  logic              s1_sysrun_q;
  logic              out_valid_q;
  logic [COLOR_W-1:0] out_color_q;
  logic              out_active_q;

  logic    r_free;
  logic    fire;
  logic    in_accept;
  result_t res;

  assign cfg_ready_o = 1'b1;
  assign r_free      = !out_valid_q || !out_stall_i;
  assign fire        = s1_valid_q && r_free;
  assign in_stall_o  = s1_valid_q && !r_free;
  assign in_accept   = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled    <= 1'b0;
      cfg_q.long_half  <= LONG_HALF_RST;
      cfg_q.short_half <= SHORT_HALF_RST;
      cfg_q.long_unit  <= LONG_UNIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ENABLED:    cfg_q.enabled    <= cfg_data_i[0];
        CFG_LONG_HALF:  cfg_q.long_half  <= cfg_data_i;
        CFG_SHORT_HALF: cfg_q.short_half <= cfg_data_i;
        CFG_LONG_UNIT:  cfg_q.long_unit  <= cfg_data_i[UNIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_kind_q   <= in_kind_i;
      s1_now_q    <= in_now_ms_i;
      s1_chan_q   <= in_channel_i;
      s1_sysrun_q <= in_system_running_i;
    end
  end

  cbs_core #(
    .MaxEntries(MaxEntries)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .kind_i  (s1_kind_q),
    .now_i   (s1_now_q),
    .chan_i  (s1_chan_q),
    .sysrun_i(s1_sysrun_q),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (r_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_free && res.valid) begin
      out_color_q  <= res.color;
      out_active_q <= res.active;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_led_color_o    = out_color_q;
  assign out_blink_active_o = out_active_q;

endmodule

// ----- bench/channel_blink_code_sequencer_test.sv -----
`timescale 1ns / 1ps

module channel_blink_code_sequencer_test;
  import cbs_pkg::*;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               active;
  } led_update_t;

  typedef enum bit {ROW_BEAT, ROW_CFG} row_op_e;

  typedef struct packed {
    row_op_e               op;
    logic                  kind;
    logic [NOW_W-1:0]      now;
    logic [CHAN_W-1:0]     chan;
    logic                  sysrun;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    bit                    typed;
    bit                    typed_has;
    led_update_t           typed_led;
  } script_row_t;

  localparam led_update_t NO_LED = '0;
  localparam int DIRECTED_ROWS = 21;
  localparam int STUCK_LIMIT = 2000;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  in_kind_i = KIND_TICK;
  logic [NOW_W-1:0]      in_now_ms_i = '0;
  logic [CHAN_W-1:0]     in_channel_i = '0;
  logic                  in_system_running_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [COLOR_W-1:0]    out_led_color_o;
  logic                  out_blink_active_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_ENABLED;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // register copy
  logic              led_enabled = 1'b0;
  logic [HALF_W-1:0] long_half = LONG_HALF_RST;
  logic [HALF_W-1:0] short_half = SHORT_HALF_RST;
  logic [UNIT_W-1:0] unit_per_long = LONG_UNIT_RST;

  // sequence state copy
  logic             seq_running = 1'b0;
  logic [NOW_W-1:0] deadline = '0;
  logic             off_next = 1'b0;
  logic [CNT_W-1:0] longs_left = '0;
  logic [CNT_W-1:0] shorts_left = '0;
  logic             blink_is_long = 1'b0;
  logic             hold_lit = 1'b0;

  led_update_t led_updates_q[$];
  led_update_t oldest_led;

  int gap_max = 10;
  int stall_max = 10;
  int stall_left = 0;
  int stuck_cycles = 0;
  int errors = 0;
  int beats_sent = 0;
  int starts_honored = 0;
  int leds_checked = 0;
  int reg_writes = 0;

  script_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_BEAT, KIND_TICK,  32'h0000_0000, 8'd0,   1'b0, CFG_ENABLED, 16'd0, 1'b1, 1'b0, NO_LED},
    '{ROW_BEAT, KIND_START, 32'd100,       8'd7,   1'b1, CFG_ENABLED, 16'd0, 1'b1, 1'b0, NO_LED},
    '{ROW_BEAT, KIND_TICK,  32'hFFFF_FFFF, 8'd0,   1'b0, CFG_ENABLED, 16'd0, 1'b1, 1'b0, NO_LED},
    '{ROW_CFG,  KIND_TICK,  32'h0000_0000, 8'd0,   1'b0, CFG_ENABLED, 16'd1, 1'b0, 1'b0, NO_LED},
    '{ROW_BEAT, KIND_START, 32'd1000,      8'd0,   1'b0, CFG_ENABLED, 16'd0, 1'b1, 1'b1,
      '{COLOR_RED, 1'b1}},
    '{ROW_BEAT, KIND_TICK,  32'hFFFF_FFFF, 8'd0,   1'b0, CFG_ENABLED, 16'd0, 1'b1, 1'b0, NO_LED},
    '{ROW_BEAT, KIND_START, 32'd0,         8'd7,   1'b1, CFG_ENABLED, 16'd0, 1'b1, 1'b1,
      '{COLOR_GREEN, 1'b1}},
    '{ROW_BEAT, KIND_TICK,  32'd400,       8'd0,   1'b0, CFG_ENABLED, 16'd0, 1'b1, 1'b0, NO_LED},
    '{ROW_BEAT, KIND_TICK,  32'd401,       8'd0,   1'b0, CFG_ENABLED, 16'd0, 1'b1, 1'b1,
      '{COLOR_OFF, 1'b1}},
    '{ROW_BEAT, KIND_TICK,  32'd5000,      8'd0,   1'b0, CFG_ENABLED, 16'd0, 1'b1, 1'b1,
      '{COLOR_GREEN, 1'b1}},
    '{ROW_BEAT, KIND_TICK,  32'd5000,      8'd0,   1'b0, CFG_ENABLED, 16'd0, 1'b0, 1'b0, NO_LED},
    '{ROW_BEAT, KIND_TICK,  32'd5000,      8'd0,   1'b0, CFG_ENABLED, 16'd0, 1'b0, 1'b0, NO_LED},
    '{ROW_BEAT, KIND_TICK,  32'd5000,      8'd0,   1'b0, CFG_ENABLED, 16'd0, 1'b1, 1'b1,
      '{COLOR_OFF, 1'b0}},
    '{ROW_BEAT, KIND_TICK,  32'd5000,      8'd0,   1'b0, CFG_ENABLED, 16'd0, 1'b1, 1'b0, NO_LED},
    '{ROW_BEAT, KIND_START, 32'd0,         8'd255, 1'b0, CFG_ENABLED, 16'd0, 1'b1, 1'b1,
      '{COLOR_RED, 1'b1}},
    '{ROW_BEAT, KIND_START, 32'hFFFF_FF00, 8'd4,   1'b1, CFG_ENABLED, 16'd0, 1'b1, 1'b1,
      '{COLOR_GREEN, 1'b1}},
    '{ROW_BEAT, KIND_TICK,  32'hFFFF_FFFF, 8'd0,   1'b0, CFG_ENABLED, 16'd0, 1'b0, 1'b0, NO_LED},
    '{ROW_CFG,  KIND_TICK,  32'h0000_0000, 8'd0,   1'b0, CFG_LONG_UNIT, 16'd1, 1'b0, 1'b0, NO_LED},
    '{ROW_BEAT, KIND_START, 32'd10,        8'd3,   1'b0, CFG_ENABLED, 16'd0, 1'b1, 1'b1,
      '{COLOR_RED, 1'b1}},
    '{ROW_BEAT, KIND_TICK,  32'h7FFF_FFFF, 8'd0,   1'b0, CFG_ENABLED, 16'd0, 1'b0, 1'b0, NO_LED},
    '{ROW_BEAT, KIND_TICK,  32'h0000_0000, 8'd0,   1'b0, CFG_ENABLED, 16'd0, 1'b0, 1'b0, NO_LED}
  };

  channel_blink_code_sequencer DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_kind_i           (in_kind_i),
    .in_now_ms_i         (in_now_ms_i),
    .in_channel_i        (in_channel_i),
    .in_system_running_i (in_system_running_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_led_color_o     (out_led_color_o),
    .out_blink_active_o  (out_blink_active_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [NOW_W-1:0] half_of(input logic is_long);
    return is_long ? NOW_W'(long_half) : NOW_W'(short_half);
  endfunction

  function automatic void take_next_blink();
    if (longs_left != 0) begin
      blink_is_long = 1'b1;
      longs_left = longs_left - 1'b1;
    end else begin
      blink_is_long = 1'b0;
      shorts_left = shorts_left - 1'b1;
    end
  endfunction

  function automatic bit blink_code_step(input logic kind, input logic [NOW_W-1:0] now,
                                         input logic [CHAN_W-1:0] chan, input logic sysrun,
                                         output led_update_t led);
    int unsigned unit;
    int unsigned longs;
    int unsigned shorts;
    led = NO_LED;
    if (kind == KIND_START) begin
      if (!led_enabled) return 1'b0;
      unit = (unit_per_long == 0) ? 32'd1 : 32'(unit_per_long);
      longs = 32'(chan) / unit;
      shorts = 32'(chan) % unit;
      if (longs > MAX_ENTRIES / 2) longs = MAX_ENTRIES / 2;
      if (shorts > MAX_ENTRIES / 2 - longs) shorts = MAX_ENTRIES / 2 - longs;
      longs_left = CNT_W'(longs);
      shorts_left = CNT_W'(shorts);
      seq_running = 1'b1;
      if (longs + shorts == 0) begin
        hold_lit = 1'b1;
        off_next = 1'b0;
        blink_is_long = 1'b0;
        deadline = now;
      end else begin
        hold_lit = 1'b0;
        take_next_blink();
        off_next = 1'b1;
        deadline = now + half_of(blink_is_long);
      end
      led.color = sysrun ? COLOR_GREEN : COLOR_RED;
      led.active = 1'b1;
      return 1'b1;
    end
    if (!seq_running || hold_lit || !(now > deadline)) return 1'b0;
    if (off_next) begin
      led.color = COLOR_OFF;
      off_next = 1'b0;
      if (longs_left == 0 && shorts_left == 0) begin
        seq_running = 1'b0;
        led.active = 1'b0;
      end else begin
        deadline = deadline + half_of(blink_is_long);
        led.active = 1'b1;
      end
    end else begin
      take_next_blink();
      deadline = deadline + half_of(blink_is_long);
      off_next = 1'b1;
      led.color = COLOR_GREEN;
      led.active = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic logic [CHAN_W-1:0] pick_channel(input logic [UNIT_W-1:0] unit);
    return $urandom_range(0, 1) ? CHAN_W'($urandom_range(0, 255))
                                : CHAN_W'($urandom_range(0, 3 * unit));
  endfunction

  task automatic send_beat(input logic kind, input logic [NOW_W-1:0] now,
                           input logic [CHAN_W-1:0] chan, input logic sysrun,
                           input bit typed, input bit typed_has, input led_update_t typed_led);
    int gap;
    bit has;
    led_update_t led;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_kind_i <= kind;
    in_now_ms_i <= now;
    in_channel_i <= chan;
    in_system_running_i <= sysrun;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (kind == KIND_START && led_enabled) starts_honored++;
    if (!(kind == KIND_START && !led_enabled)) beats_sent++;
    has = blink_code_step(kind, now, chan, sysrun, led);
    if (typed) begin
      has = typed_has;
      led = typed_led;
    end
    if (has) led_updates_q.push_back(led);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                           input bit more);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    reg_writes++;
    case (idx)
      CFG_ENABLED:    led_enabled = data[0];
      CFG_LONG_HALF:  long_half = data;
      CFG_SHORT_HALF: short_half = data;
      CFG_LONG_UNIT:  unit_per_long = data[UNIT_W-1:0];
      default: ;
    endcase
    if (!more) cfg_valid_i <= 1'b0;
  endtask

  // drain, then let dropped beats clear the pipeline
  task automatic settle();
    in_valid_i <= 1'b0;
    while (led_updates_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic en, input logic [HALF_W-1:0] lh,
                           input logic [HALF_W-1:0] sh, input logic [UNIT_W-1:0] unit,
                           input int gaps, input int stalls, input int n);
    int goal;
    int ticks;
    int mode;
    logic [NOW_W-1:0] now;
    logic [NOW_W-1:0] span;
    settle();
    cfg_write(CFG_ENABLED, CFG_DATA_W'(en), 1'b1);
    cfg_write(CFG_LONG_HALF, lh, 1'b1);
    cfg_write(CFG_SHORT_HALF, sh, 1'b1);
    cfg_write(CFG_LONG_UNIT, CFG_DATA_W'(unit), 1'b0);
    gap_max = gaps;
    stall_max = stalls;
    span = 2 * NOW_W'((lh > sh) ? lh : sh) + 1;
    goal = beats_sent + n;
    while (beats_sent < goal) begin
      mode = $urandom_range(0, 9);
      if (mode == 7) begin
        send_beat(KIND_TICK, $urandom, CHAN_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'b0, 1'b0, NO_LED);
      end else if (mode == 8) begin
        send_beat(KIND_START, $urandom, CHAN_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'b0, 1'b0, NO_LED);
      end else begin
        now = (mode == 9) ? 32'hFFFF_FFFF - $urandom_range(0, span) : $urandom;
        send_beat(KIND_START, now, pick_channel(unit), 1'($urandom_range(0, 1)),
                  1'b0, 1'b0, NO_LED);
        ticks = 0;
        while (ticks < 60 && ((seq_running && !hold_lit) || ticks < 3) && beats_sent < goal)
        begin
          if ($urandom_range(0, 19) == 0) begin
            send_beat(KIND_START, now, pick_channel(unit), 1'($urandom_range(0, 1)),
                      1'b0, 1'b0, NO_LED);
          end else begin
            if ($urandom_range(0, 7) == 0) now = deadline + $urandom_range(0, 1);
            else now = now + $urandom_range(0, span);
            send_beat(KIND_TICK, now, CHAN_W'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'b0, 1'b0, NO_LED);
          end
          ticks++;
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) stall_left = $urandom_range(0, stall_max);
    else if (stall_left > 0) stall_left--;
    out_stall_i <= (stall_left != 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      leds_checked++;
      if (led_updates_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected LED beat, expected none, got color %0d active %0d",
                 $time, out_led_color_o, out_blink_active_o);
      end else begin
        oldest_led = led_updates_q.pop_front();
        if (out_led_color_o !== oldest_led.color) begin
          errors++;
          $display("%0t: led_color expected %0d got %0d",
                   $time, oldest_led.color, out_led_color_o);
        end
        if (out_blink_active_o !== oldest_led.active) begin
          errors++;
          $display("%0t: blink_active expected %0d got %0d",
                   $time, oldest_led.active, out_blink_active_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d LED beats outstanding",
               $time, stuck_cycles, led_updates_q.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].op == ROW_CFG) begin
        settle();
        cfg_write(directed_rows[r].reg_idx, directed_rows[r].reg_data, 1'b0);
      end else begin
        send_beat(directed_rows[r].kind, directed_rows[r].now, directed_rows[r].chan,
                  directed_rows[r].sysrun, directed_rows[r].typed,
                  directed_rows[r].typed_has, directed_rows[r].typed_led);
      end
    end

    run_phase(1'b1, 16'd3, 16'd1, 4'd5, 10, 10, 350);
    run_phase(1'b1, 16'd1, 16'd1, 4'd1, 0, 0, 300);
    run_phase(1'b1, 16'hFFFF, 16'hFFFF, 4'd15, 10, 10, 250);
    run_phase(1'b0, 16'd5, 16'd9, 4'd4, 3, 10, 150);
    run_phase(1'b1, HALF_W'($urandom_range(1, 60)), HALF_W'($urandom_range(1, 60)),
              UNIT_W'($urandom_range(1, 15)), 10, 0, 350);
    run_phase(1'b1, 16'd2, 16'd7, 4'd3, 0, 10, 300);
    run_phase(1'b1, HALF_W'($urandom_range(1, 65535)), HALF_W'($urandom_range(1, 65535)),
              UNIT_W'($urandom_range(1, 15)), 10, 10, 300);

    in_valid_i <= 1'b0;
    while (led_updates_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d tick/start beats (%0d honored starts) across %0d register writes;",
             beats_sent, starts_honored, reg_writes);
    $display("compared %0d LED beats, %0d mismatches.", leds_checked, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
